### hw/rtl/rdsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Radix digit string converter package
// Shared widths, register codes, divider interface types and radix helpers.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    localparam int VAL_W         = 30;  // binary value of one input word
    localparam int RADIX_W       = 4;
    localparam int DIGIT_W       = 4;
    localparam int REM_W         = 5;   // raw remainder before correction (< 2 * radix)
    localparam int RECIP_W       = 32;
    localparam int OUT_DIGITS    = 19;
    localparam int OUT_CNT_W     = 5;
    localparam int RES_W         = 64;
    localparam int IN_DIGITS_DEF = 9;
    localparam int ADDR_W        = 3;
    localparam int APB_DATA_W    = 32;
    localparam int S_DATA_W      = 32;
    localparam int M_DATA_W      = 72;

    localparam logic [RADIX_W-1:0] DEC_RADIX = 4'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 4'd10;
    localparam logic [RADIX_W-1:0] SRC_RESET = 4'd10;
    localparam logic [RADIX_W-1:0] DST_RESET = 4'd2;

    // Register index codes, taken from paddr[2].
    localparam logic REG_SRC = 1'b0;
    localparam logic REG_DST = 1'b1;

    typedef struct packed {
        logic                start;
        logic [VAL_W-1:0]    dividend;
        logic [RADIX_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [VAL_W-1:0]    quotient;
        logic [DIGIT_W-1:0]  remainder;
    } div_rsp_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] c;
        begin
            if (r < RADIX_MIN) begin
                c = RADIX_MIN;
            end else if (r > RADIX_MAX) begin
                c = RADIX_MAX;
            end else begin
                c = r;
            end
            return c;
        end
    endfunction

    // floor(2^32 / k) for the radixes the divider serves.
    function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] k);
        logic [RECIP_W-1:0] m;
        begin
            case (k)
                4'd2:    m = 32'h8000_0000;
                4'd3:    m = 32'h5555_5555;
                4'd4:    m = 32'h4000_0000;
                4'd5:    m = 32'h3333_3333;
                4'd6:    m = 32'h2AAA_AAAA;
                4'd7:    m = 32'h2492_4924;
                4'd8:    m = 32'h2000_0000;
                4'd9:    m = 32'h1C71_C71C;
                4'd10:   m = 32'h1999_9999;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

### hw/rtl/rdsc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Small-radix divider
// Divides a 30-bit value by a radix of 2 to 10 with a reciprocal multiply,
// a back-multiply and one correction step (states D_MUL, D_BACK, D_FIX).
// ----------------------------------------------------------------------------
module rdsc_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rdsc_pkg::div_req_t req,
    output rdsc_pkg::div_rsp_t     rsp
);

    localparam int VW = rdsc_pkg::VAL_W;
    localparam int RW = rdsc_pkg::RADIX_W;
    localparam int MW = rdsc_pkg::RECIP_W;
    localparam int EW = rdsc_pkg::REM_W;
    localparam int DW = rdsc_pkg::DIGIT_W;

    typedef enum logic [1:0] {D_IDLE, D_MUL, D_BACK, D_FIX} div_state_t;

    div_state_t     state_reg;
    logic [VW-1:0]  dvd_reg;
    logic [RW-1:0]  dvs_reg;
    logic [VW-1:0]  qest_reg;
    logic [VW-1:0]  qd_reg;
    logic           done_reg;
    logic [VW-1:0]  quot_reg;
    logic [DW-1:0]  rem_reg;

    logic [VW+MW-1:0] prod;
    logic [VW+RW-1:0] back;
    logic [VW-1:0]    diff;
    logic [EW-1:0]    r_raw;
    logic [EW-1:0]    r_fix;
    logic [EW-1:0]    dvs_ext;
    logic             fix;

    // The estimate is never high and at most one below the true quotient.
    assign prod    = {{MW{1'b0}}, dvd_reg} * {{VW{1'b0}}, rdsc_pkg::recip(dvs_reg)};
    assign back    = {{RW{1'b0}}, qest_reg} * {{VW{1'b0}}, dvs_reg};
    assign diff    = dvd_reg - qd_reg;
    assign r_raw   = diff[EW-1:0];
    assign dvs_ext = {{(EW-RW){1'b0}}, dvs_reg};
    assign r_fix   = r_raw - dvs_ext;
    assign fix     = (r_raw >= dvs_ext);

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    dvd_reg   <= req.dividend;
                    dvs_reg   <= req.divisor;
                    state_reg <= D_MUL;
                end
            end
            D_MUL: begin
                qest_reg  <= prod[VW+MW-1:MW];
                state_reg <= D_BACK;
            end
            D_BACK: begin
                qd_reg    <= back[VW-1:0];
                state_reg <= D_FIX;
            end
            D_FIX: begin
                quot_reg  <= qest_reg + {{(VW-1){1'b0}}, fix};
                rem_reg   <= fix ? r_fix[DW-1:0] : r_raw[DW-1:0];
                done_reg  <= 1'b1;
                state_reg <= D_IDLE;
            end
            default: begin
                state_reg <= D_IDLE;
            end
        endcase
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

### hw/rtl/radix_digit_string_converter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Radix digit string converter
// Reads the decimal digits of a word as source-radix digits and writes the
// value back out with destination-radix digits as decimal digits.
// ----------------------------------------------------------------------------
// One word is worked on at a time and s_tready is high only while the block
// is idle. All divisions go through one shared divider, and each digit also
// takes a step of weighting or packing. The number of destination digits is
// at most 19, and a word that overflows stops after 19 divisions. A 19-digit
// result, such as binary output of a large input, is the slow case. A finished
// word waits in the output register, so the next word is accepted while it is
// still held on m_tdata.
module radix_digit_string_converter_top #(
    parameter int IN_DIGITS = rdsc_pkg::IN_DIGITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // APB configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rdsc_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [rdsc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [rdsc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    // Input words
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rdsc_pkg::S_DATA_W-1:0]     s_tdata,  // [29:0] digit_word
    // Result words
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [rdsc_pkg::M_DATA_W-1:0]     m_tdata   // [63:0] result_word, [64] overflow
);

    localparam int VW    = rdsc_pkg::VAL_W;
    localparam int RW    = rdsc_pkg::RADIX_W;
    localparam int DW    = rdsc_pkg::DIGIT_W;
    localparam int IDW   = IN_DIGITS * DW;
    localparam int ODW   = rdsc_pkg::OUT_DIGITS * DW;
    localparam int OCW   = rdsc_pkg::OUT_CNT_W;
    localparam int RES_W = rdsc_pkg::RES_W;
    localparam int CNT_W = (IN_DIGITS > 1) ? $clog2(IN_DIGITS) : 1;
    localparam logic [CNT_W-1:0] ICNT_LAST = CNT_W'(IN_DIGITS - 1);
    localparam logic [OCW-1:0]   OCNT_LAST = OCW'(rdsc_pkg::OUT_DIGITS - 1);

    typedef enum logic [2:0] {S_IDLE, S_SPLIT, S_HORNER, S_CONV, S_PACK, S_DONE} state_t;

    state_t              state_reg;
    logic [RW-1:0]       src_reg;
    logic [RW-1:0]       dst_reg;
    logic                start_reg;
    logic [VW-1:0]       dvd_reg;
    logic [RW-1:0]       dvs_reg;
    logic [IDW-1:0]      dig_reg;
    logic [CNT_W-1:0]    icnt_reg;
    logic [VW-1:0]       val_reg;
    logic [ODW-1:0]      odig_reg;
    logic [OCW-1:0]      ocnt_reg;
    logic                ovf_reg;
    logic [RES_W-1:0]    res_reg;
    logic                m_tvalid_reg;
    logic [RES_W-1:0]    m_res_reg;
    logic                m_ovf_reg;

    rdsc_pkg::div_req_t  div_req;
    rdsc_pkg::div_rsp_t  div_rsp;

    logic [RW-1:0]       sr;
    logic [RW-1:0]       dr;
    logic [IDW+DW-1:0]   dig_cat;
    logic [DW-1:0]       top_digit;
    logic [VW+RW-1:0]    hsum;
    logic [VW-1:0]       hval;
    logic [RES_W-1:0]    res_step;
    logic                apb_wr;

    assign sr        = rdsc_pkg::clamp_radix(src_reg);
    assign dr        = rdsc_pkg::clamp_radix(dst_reg);
    assign dig_cat   = {div_rsp.remainder, dig_reg};
    assign top_digit = dig_reg[IDW-1 -: DW];
    assign hsum      = ({{RW{1'b0}}, val_reg} * {{VW{1'b0}}, sr})
                       + {{VW{1'b0}}, top_digit};
    // The weighted sum never exceeds the value of all nine digits, so 30 bits hold it.
    assign hval      = hsum[VW-1:0];
    assign res_step  = (res_reg << 3) + (res_reg << 1)
                       + {{(RES_W-DW){1'b0}}, odig_reg[DW-1:0]};

    assign div_req.start    = start_reg;
    assign div_req.dividend = dvd_reg;
    assign div_req.divisor  = dvs_reg;

    rdsc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Configuration port
    assign apb_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {{(rdsc_pkg::APB_DATA_W-RW){1'b0}},
                     (paddr[2] == rdsc_pkg::REG_DST) ? dst_reg : src_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg <= rdsc_pkg::SRC_RESET;
            dst_reg <= rdsc_pkg::DST_RESET;
        end else if (apb_wr) begin
            case (paddr[2])
                rdsc_pkg::REG_SRC: src_reg <= pwdata[RW-1:0];
                rdsc_pkg::REG_DST: dst_reg <= pwdata[RW-1:0];
                default:           src_reg <= src_reg;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(rdsc_pkg::M_DATA_W-RES_W-1){1'b0}}, m_ovf_reg, m_res_reg};

    always_ff @(posedge aclk) begin
        start_reg <= 1'b0;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    dvd_reg   <= s_tdata[VW-1:0];
                    dvs_reg   <= rdsc_pkg::DEC_RADIX;
                    start_reg <= 1'b1;
                    icnt_reg  <= '0;
                    state_reg <= S_SPLIT;
                end
            end
            // Peel decimal digits off the input word, least significant first.
            S_SPLIT: begin
                if (div_rsp.done) begin
                    dig_reg <= dig_cat[IDW+DW-1:DW];
                    if (icnt_reg == ICNT_LAST) begin
                        icnt_reg  <= '0;
                        val_reg   <= '0;
                        state_reg <= S_HORNER;
                    end else begin
                        icnt_reg  <= icnt_reg + CNT_W'(1);
                        dvd_reg   <= div_rsp.quotient;
                        start_reg <= 1'b1;
                    end
                end
            end
            // Weight the digits by the source radix, most significant first.
            S_HORNER: begin
                val_reg  <= hval;
                dig_reg  <= dig_reg << DW;
                icnt_reg <= icnt_reg + CNT_W'(1);
                if (icnt_reg == ICNT_LAST) begin
                    ocnt_reg <= '0;
                    ovf_reg  <= 1'b0;
                    res_reg  <= '0;
                    if (hval == '0) begin
                        state_reg <= S_PACK;
                    end else begin
                        dvd_reg   <= hval;
                        dvs_reg   <= dr;
                        start_reg <= 1'b1;
                        state_reg <= S_CONV;
                    end
                end
            end
            // Destination digits come out least significant first.
            S_CONV: begin
                if (div_rsp.done) begin
                    odig_reg <= {odig_reg[ODW-DW-1:0], div_rsp.remainder};
                    ocnt_reg <= ocnt_reg + OCW'(1);
                    if (div_rsp.quotient == '0) begin
                        state_reg <= S_PACK;
                    end else if (ocnt_reg == OCNT_LAST) begin
                        ovf_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        dvd_reg   <= div_rsp.quotient;
                        start_reg <= 1'b1;
                    end
                end
            end
            // The lowest nibble holds the most significant digit.
            S_PACK: begin
                if (ocnt_reg == '0) begin
                    state_reg <= S_DONE;
                end else begin
                    res_reg  <= res_step;
                    odig_reg <= odig_reg >> DW;
                    ocnt_reg <= ocnt_reg - OCW'(1);
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_res_reg    <= ovf_reg ? '0 : res_reg;
                    m_ovf_reg    <= ovf_reg;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
            end
            default: begin
                state_reg <= S_IDLE;
            end
        endcase
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/rdsc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Radix digit string converter checker
// Port-level assertions on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rdsc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rdsc_pkg::M_DATA_W-1:0]   m_tdata,
    input wire logic                            pready
);

    // A word waiting on the result side holds still until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // An overflowed result carries no digits.
    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[64] |-> m_tdata[63:0] == 64'd0)
        else $error("overflow result is not zero");

    // The converter does not take another word right after accepting one.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken again while converting");

    // A result can never appear right after an input word is taken.
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready && (m_tdata[71:65] == 7'd0 || !m_tvalid))
        else $error("pready low or result padding not zero");

endmodule

bind radix_digit_string_converter_top rdsc_checker u_rdsc_checker (.*);
`default_nettype wire
